/* sv/rles_pkg.sv */
// rles_pkg: shared constants for the row lane edge scanner
// pixel codes, configuration register indexes and reset values
// no dependencies
package rles_pkg;

    localparam int unsigned CFG_DATA_BITS  = 13;
    localparam int unsigned CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_START_ROW    = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    localparam logic [7:0] PIX_WHITE = 8'd255;
    localparam logic [7:0] PIX_BLACK = 8'd0;

    localparam logic [12:0] FRAME_WIDTH_RESET  = 13'd1280;
    localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd720;
    localparam logic [11:0] START_ROW_RESET    = 12'd460;

endpackage

/* sv/row_lane_edge_scan.sv */
// row_lane_edge_scan: finds lane edges either side of the centre column per row
// of a thresholded raster stream; depends on rles_pkg
//
// usage
//   pixel channel (pix_valid / pix_stall, pixel, frame_start): one pixel per
//   transaction in raster order, frame_start marks row 0 column 0
//   edge channel (edge_valid / edge_stall): one transaction per scanned row
//   (start_row .. frame_height-2), carrying row_index and both edge columns
//   configuration: cfg_write with cfg_index / cfg_data, only while idle
// throughput and result register
//   one pixel per cycle while no pixel is stalled; the row result appears in
//   the result register in the cycle after the last pixel of its row is accepted
//   per pixel the work is a compare pair and counter update between the
//   position/edge registers and the result register
// stalls
//   while a result waits under edge_stall, pixels that end no scanned row are
//   still taken; a pixel that would emit a result is stalled until it drains
// reset
//   configuration returns to 1280 x 720 with start row 460, counters and
//   edge state clear, no result pending
module row_lane_edge_scan
    import rles_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      pix_valid,
    output logic                      pix_stall,
    input  logic [7:0]                pixel,
    input  logic                      frame_start,
    output logic                      edge_valid,
    input  logic                      edge_stall,
    output logic [COORD_BITS-1:0]     row_index,
    output logic [COORD_BITS-1:0]     left_col,
    output logic                      left_found,
    output logic [COORD_BITS-1:0]     right_col,
    output logic                      right_found
);

    // compare width covers 13-bit registers, 2^COORD_BITS and a +2 margin
    localparam int unsigned BASE_BITS = (COORD_BITS > CFG_DATA_BITS) ? COORD_BITS
                                                                     : CFG_DATA_BITS;
    localparam int unsigned CMP_BITS  = BASE_BITS + 2;
    localparam logic [CMP_BITS-1:0] SPAN = {{(CMP_BITS-1){1'b0}}, 1'b1} << COORD_BITS;
    localparam logic [CMP_BITS-1:0] ONE  = {{(CMP_BITS-1){1'b0}}, 1'b1};
    localparam logic [CMP_BITS-1:0] TWO  = {{(CMP_BITS-2){1'b0}}, 2'b10};

    logic [12:0]           frame_width_reg;
    logic [12:0]           frame_height_reg;
    logic [11:0]           start_row_reg;

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [7:0]            prev_pix_reg;
    logic [COORD_BITS-1:0] left_edge_reg, left_edge_next;
    logic                  left_seen_reg, left_seen_next;
    logic [COORD_BITS-1:0] right_edge_reg, right_edge_next;
    logic                  right_seen_reg, right_seen_next;

    logic                  edge_valid_reg;
    logic [COORD_BITS-1:0] row_index_reg;
    logic [COORD_BITS-1:0] left_col_reg;
    logic                  left_found_reg;
    logic [COORD_BITS-1:0] right_col_reg;
    logic                  right_found_reg;

    logic [CMP_BITS-1:0]   fw_ext, fh_ext, w_eff, h_eff, centre;
    logic [CMP_BITS-1:0]   c_ext, r_ext, c_plus1, r_plus1, sr_ext;
    logic [COORD_BITS-1:0] c_cur, r_cur;
    logic                  row_end, scanned, emit, pix_accept;

    // effective frame size, clamped to 1 .. 2^COORD_BITS
    always_comb
    begin
        fw_ext = CMP_BITS'(frame_width_reg);
        fh_ext = CMP_BITS'(frame_height_reg);
        if (fw_ext == '0)
            w_eff = ONE;
        else if (fw_ext > SPAN)
            w_eff = SPAN;
        else
            w_eff = fw_ext;
        if (fh_ext == '0)
            h_eff = ONE;
        else if (fh_ext > SPAN)
            h_eff = SPAN;
        else
            h_eff = fh_ext;
        centre = w_eff >> 1;
    end

    always_comb
    begin
        c_cur   = frame_start ? '0 : col_reg;
        r_cur   = frame_start ? '0 : row_reg;
        c_ext   = CMP_BITS'(c_cur);
        r_ext   = CMP_BITS'(r_cur);
        sr_ext  = CMP_BITS'(start_row_reg);
        c_plus1 = c_ext + ONE;
        r_plus1 = r_ext + ONE;

        left_edge_next  = left_edge_reg;
        left_seen_next  = left_seen_reg;
        right_edge_next = right_edge_reg;
        right_seen_next = right_seen_reg;

        if (c_cur == '0)
        begin
            left_edge_next  = '0;
            left_seen_next  = 1'b0;
            right_edge_next = '0;
            right_seen_next = 1'b0;
        end
        else
        begin
            // white then black, first one at or right of centre
            if (!right_seen_reg && prev_pix_reg == PIX_WHITE && pixel == PIX_BLACK &&
                (c_ext - ONE) >= centre && c_plus1 <= w_eff)
            begin
                right_edge_next = c_cur - 1'b1;
                right_seen_next = 1'b1;
            end
            // black then white, the last one at or left of centre wins
            if (prev_pix_reg == PIX_BLACK && pixel == PIX_WHITE && c_ext <= centre)
            begin
                left_edge_next = c_cur;
                left_seen_next = 1'b1;
            end
        end

        row_end = (c_plus1 >= w_eff);
        scanned = (r_ext >= sr_ext) && ((r_ext + TWO) <= h_eff);
        emit    = row_end && scanned;

        if (row_end)
        begin
            col_next = '0;
            row_next = (r_plus1 >= h_eff) ? '0 : r_plus1[COORD_BITS-1:0];
        end
        else
        begin
            col_next = c_plus1[COORD_BITS-1:0];
            row_next = r_cur;
        end
    end

    // only a pixel that ends a scanned row has to wait for the result register
    assign pix_stall  = edge_valid_reg && edge_stall && emit;
    assign pix_accept = pix_valid && !pix_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            start_row_reg    <= START_ROW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                CFG_START_ROW:    start_row_reg    <= cfg_data[11:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            prev_pix_reg   <= '0;
            left_edge_reg  <= '0;
            left_seen_reg  <= 1'b0;
            right_edge_reg <= '0;
            right_seen_reg <= 1'b0;
        end
        else if (pix_accept)
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            prev_pix_reg   <= pixel;
            left_edge_reg  <= left_edge_next;
            left_seen_reg  <= left_seen_next;
            right_edge_reg <= right_edge_next;
            right_seen_reg <= right_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            edge_valid_reg <= 1'b0;
        else if (!edge_valid_reg || !edge_stall)
            edge_valid_reg <= pix_accept && emit;
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept && emit)
        begin
            row_index_reg   <= r_cur;
            left_col_reg    <= left_seen_next ? left_edge_next : '0;
            left_found_reg  <= left_seen_next;
            right_col_reg   <= right_seen_next ? right_edge_next : '0;
            right_found_reg <= right_seen_next;
        end
    end

    assign edge_valid  = edge_valid_reg;
    assign row_index   = row_index_reg;
    assign left_col    = left_col_reg;
    assign left_found  = left_found_reg;
    assign right_col   = right_col_reg;
    assign right_found = right_found_reg;

    // input held back only by a pending, stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (edge_valid_reg && edge_stall))
        else $error("pixel stalled without a blocked result");

    // frame start restarts the column count
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_accept && frame_start && w_eff > ONE) |=> (col_reg == {{(COORD_BITS-1){1'b0}}, 1'b1}))
        else $error("frame start did not restart the column count");

    // a result with no edge carries column zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (edge_valid_reg && (!left_found_reg || !right_found_reg)) |->
        ((left_found_reg || left_col_reg == '0) && (right_found_reg || right_col_reg == '0)))
        else $error("edge column set without a found flag");

    // a taken result leaves unless a new row result replaces it
    assert property (@(posedge clk) disable iff (!rst_n)
        (edge_valid_reg && !edge_stall && !(pix_accept && emit)) |=> !edge_valid_reg)
        else $error("result repeated after transaction");

endmodule

/* bench/tb_row_lane_edge_scan.sv */
// tb_row_lane_edge_scan: self-checking bench for the row lane edge scanner
// drives raster pixel streams under many frame geometries and checks every row
// result against an in-bench edge predictor; depends on rles_pkg and the block
module tb_row_lane_edge_scan;
    import rles_pkg::*;

    localparam int unsigned COORD_BITS    = 12;
    localparam int unsigned COORD_SPAN    = 1 << COORD_BITS;
    localparam int unsigned IDLE_PERCENT  = 16;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_PIXELS = 280;

    typedef struct packed {
        logic [11:0] row_no;
        logic [11:0] lcol;
        logic        lhit;
        logic [11:0] rcol;
        logic        rhit;
    } edge_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_write = 1'b0;
    cfg_index_t   cfg_index = CFG_FRAME_WIDTH;
    logic [12:0]  cfg_data = '0;
    logic         pix_valid = 1'b0;
    logic         pix_stall;
    logic [7:0]   pixel = '0;
    logic         frame_start = 1'b0;
    logic         edge_valid;
    logic         edge_stall = 1'b0;
    logic [11:0]  row_index;
    logic [11:0]  left_col;
    logic         left_found;
    logic [11:0]  right_col;
    logic         right_found;

    // predictor copy of the registers and scan state
    logic [12:0]  model_width = FRAME_WIDTH_RESET;
    logic [12:0]  model_height = FRAME_HEIGHT_RESET;
    logic [11:0]  model_start = START_ROW_RESET;
    logic [11:0]  scan_col = '0;
    logic [11:0]  scan_row = '0;
    logic [7:0]   prior_pixel = '0;
    logic [11:0]  left_at = '0;
    logic [11:0]  right_at = '0;
    logic         left_hit = 1'b0;
    logic         right_hit = 1'b0;

    edge_result_t edge_results_due[$];
    int unsigned  mismatches = 0;
    int unsigned  pixels_sent = 0;
    int unsigned  idle_cycles = 0;
    bit           quiet = 1'b0;

    row_lane_edge_scan DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .edge_valid  (edge_valid),
        .edge_stall  (edge_stall),
        .row_index   (row_index),
        .left_col    (left_col),
        .left_found  (left_found),
        .right_col   (right_col),
        .right_found (right_found)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned clamp_span(input logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > COORD_SPAN)
            return COORD_SPAN;
        return v;
    endfunction

    task automatic predict_pixel(input logic [7:0] p, input logic fs);
        int unsigned  w;
        int unsigned  h;
        int unsigned  centre;
        int unsigned  c;
        int unsigned  r;
        edge_result_t res;
        w = clamp_span(model_width);
        h = clamp_span(model_height);
        centre = w >> 1;
        if (fs)
        begin
            scan_col = '0;
            scan_row = '0;
        end
        c = scan_col;
        r = scan_row;
        if (c == 0)
        begin
            left_hit = 1'b0;
            left_at = '0;
            right_hit = 1'b0;
            right_at = '0;
        end
        else
        begin
            // first white-to-black step at or right of centre
            if (!right_hit && prior_pixel == PIX_WHITE && p == PIX_BLACK
                && c - 1 >= centre && c + 1 <= w)
            begin
                right_at = 12'(c - 1);
                right_hit = 1'b1;
            end
            // last black-to-white step up to centre wins
            if (prior_pixel == PIX_BLACK && p == PIX_WHITE && c <= centre)
            begin
                left_at = 12'(c);
                left_hit = 1'b1;
            end
        end
        prior_pixel = p;
        if (c + 1 >= w)
        begin
            if (r >= model_start && r + 2 <= h)
            begin
                res.row_no = 12'(r);
                res.lcol = left_hit ? left_at : 12'd0;
                res.lhit = left_hit;
                res.rcol = right_hit ? right_at : 12'd0;
                res.rhit = right_hit;
                edge_results_due = {edge_results_due, res};
            end
            scan_col = '0;
            scan_row = (r + 1 >= h) ? 12'd0 : 12'(r + 1);
        end
        else
            scan_col = 12'(c + 1);
    endtask

    task automatic send_pixel(input logic [7:0] p, input logic fs);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pixel <= p;
        frame_start <= fs;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        predict_pixel(p, fs);
        pixels_sent++;
        @(negedge clk);
    endtask

    // eight pixels, leftmost in the top byte
    task automatic send_row8(input logic [63:0] row, input bit open_frame);
        for (int i = 0; i < 8; i++)
            send_pixel(row[63 - 8*i -: 8], open_frame && i == 0);
    endtask

    // runs of black and white with a sprinkle of grey, or plain noise
    task automatic send_lane_row(input int unsigned len, input bit open_frame);
        logic [7:0]  shade;
        logic [7:0]  p;
        int unsigned run;
        bit          scramble;
        scramble = ($urandom_range(0, 3) == 0);
        shade = $urandom_range(0, 1) ? PIX_WHITE : PIX_BLACK;
        run = $urandom_range(1, len / 3 + 1);
        for (int unsigned col = 0; col < len; col++)
        begin
            if (scramble)
            begin
                case ($urandom_range(0, 2))
                    0: p = PIX_BLACK;
                    1: p = PIX_WHITE;
                    default: p = 8'($urandom_range(0, 255));
                endcase
            end
            else if ($urandom_range(0, 99) < 6)
                p = 8'($urandom_range(0, 255));
            else
                p = shade;
            send_pixel(p, open_frame && col == 0);
            run = run - 1;
            if (run == 0)
            begin
                shade = (shade == PIX_WHITE) ? PIX_BLACK : PIX_WHITE;
                run = $urandom_range(1, len / 3 + 1);
            end
        end
    endtask

    // stop feeding and let every pending row result come out
    task automatic drain_results();
        pix_valid <= 1'b0;
        while (edge_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [12:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_FRAME_WIDTH:  model_width = value;
            CFG_FRAME_HEIGHT: model_height = value;
            CFG_START_ROW:    model_start = value[11:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(input logic [12:0] w, input logic [12:0] h,
                                input logic [12:0] s);
        drain_results();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_START_ROW, s);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        edge_result_t due;
        if (rst_n && edge_valid && !edge_stall)
        begin
            if (edge_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row result for row %0d", row_index);
            end
            else
            begin
                due = edge_results_due.pop_front();
                check_field("row_index", due.row_no, row_index);
                check_field("left_col", due.lcol, left_col);
                check_field("left_found", due.lhit, left_found);
                check_field("right_col", due.rcol, right_col);
                check_field("right_found", due.rhit, right_found);
            end
        end
    end

    always @(negedge clk)
        edge_stall <= !quiet && $urandom_range(0, 99) < IDLE_PERCENT;

    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (edge_valid && !edge_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_row_lane_edge_scan NOT OK");
            $finish;
        end
    end

    // reset geometry: no row ends early in row 0, then a narrower width closes it
    task automatic test_reset_defaults();
        send_pixel(PIX_BLACK, 1'b1);
        for (int i = 1; i < 20; i++)
            send_pixel($urandom_range(0, 1) ? PIX_WHITE : PIX_BLACK, 1'b0);
        drain_results();
        write_reg(CFG_START_ROW, 13'd0);
        write_reg(CFG_FRAME_WIDTH, 13'd24);
        send_lane_row(4, 1'b0);
    endtask

    // edges at the window limits, several left edges, row boundary pairs
    task automatic test_edge_positions();
        set_geometry(13'd8, 13'd4, 13'd0);
        send_row8({8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255}, 1'b1);
        send_row8({8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0}, 1'b0);
        send_row8({8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0}, 1'b0);
    endtask

    // frame start in the middle of a row and again at a row boundary
    task automatic test_frame_restart();
        set_geometry(13'd6, 13'd3, 13'd0);
        send_pixel(PIX_WHITE, 1'b1);
        send_pixel(PIX_BLACK, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_BLACK, 1'b1);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_BLACK, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_BLACK, 1'b0);
        send_pixel(PIX_BLACK, 1'b0);
        send_lane_row(6, 1'b1);
    endtask

    // widths 0 to 3: every pixel or every few pixels ends a row
    task automatic test_tiny_widths();
        for (int w = 0; w < 4; w++)
        begin
            set_geometry(13'(w), 13'd5, 13'd0);
            send_pixel(PIX_BLACK, 1'b1);
            for (int i = 0; i < 5; i++)
                send_pixel($urandom_range(0, 1) ? PIX_WHITE : PIX_BLACK, 1'b0);
        end
        send_pixel(PIX_BLACK, 1'b1);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_BLACK, 1'b0);
    endtask

    // heights with no scanned row, start rows past the end, then one row
    task automatic test_short_heights();
        set_geometry(13'd4, 13'd0, 13'd0);
        send_lane_row(4, 1'b1);
        send_lane_row(4, 1'b0);
        drain_results();
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        send_lane_row(4, 1'b1);
        send_lane_row(4, 1'b0);
        set_geometry(13'd4, 13'd6, 13'd5);
        for (int i = 0; i < 6; i++)
            send_lane_row(4, i == 0);
        drain_results();
        write_reg(CFG_START_ROW, 13'd4095);
        for (int i = 0; i < 6; i++)
            send_lane_row(4, i == 0);
        drain_results();
        write_reg(CFG_START_ROW, 13'd4);
        for (int i = 0; i < 7; i++)
            send_lane_row(4, i == 0);
    endtask

    // shrink width and height under live counters, then wrap without a frame start
    task automatic test_counter_overrun();
        set_geometry(13'd16, 13'd8, 13'd0);
        send_pixel(PIX_BLACK, 1'b1);
        for (int i = 1; i < 10; i++)
            send_pixel((i % 3 == 0) ? PIX_WHITE : PIX_BLACK, 1'b0);
        drain_results();
        write_reg(CFG_FRAME_WIDTH, 13'd6);
        send_pixel(PIX_WHITE, 1'b0);
        for (int i = 0; i < 4; i++)
            send_lane_row(6, 1'b0);
        send_pixel(PIX_BLACK, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);
        drain_results();
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        send_lane_row(4, 1'b0);
        for (int i = 0; i < 4; i++)
            send_lane_row(6, 1'b0);
    endtask

    // the spare register index must leave the geometry alone
    task automatic test_unused_register();
        drain_results();
        write_reg(CFG_UNUSED, 13'($urandom_range(0, 8191)));
        write_reg(CFG_UNUSED, 13'h1FFF);
        send_lane_row(6, 1'b1);
        send_lane_row(6, 1'b0);
    endtask

    // width and height above the span, one-pixel rows, start row near the top
    task automatic test_wide_frames();
        set_geometry(13'h1FFF, 13'h1FFF, 13'd0);
        send_lane_row(20, 1'b1);
        drain_results();
        write_reg(CFG_FRAME_WIDTH, 13'd24);
        send_lane_row(4, 1'b0);
        set_geometry(13'd0, 13'h1FFF, 13'd0);
        send_pixel(PIX_WHITE, 1'b1);
        for (int i = 0; i < 30; i++)
            send_pixel(8'($urandom_range(0, 255)), 1'b0);
        drain_results();
        write_reg(CFG_START_ROW, 13'd4095);
        for (int i = 0; i < 8; i++)
            send_pixel(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_random_frames();
        int unsigned pix_base;
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        int unsigned s;
        int unsigned n_rows;
        int unsigned kind;
        bit          open_frame;
        pix_base = pixels_sent;
        while (pixels_sent - pix_base < RANDOM_PIXELS)
        begin
            drain_results();
            // a stretch with no idling on either side
            quiet = (pixels_sent - pix_base >= 80 && pixels_sent - pix_base < 200);
            pick = $urandom_range(0, 99);
            w = (pick < 80) ? $urandom_range(4, 24)
              : (pick < 95) ? $urandom_range(0, 3) : $urandom_range(25, 200);
            pick = $urandom_range(0, 99);
            h = (pick < 80) ? $urandom_range(2, 8)
              : (pick < 90) ? $urandom_range(0, 1) : $urandom_range(9, 20);
            pick = $urandom_range(0, 99);
            s = (pick < 80) ? $urandom_range(0, h)
              : (pick < 90) ? 0 : $urandom_range(0, 4095);
            set_geometry(13'(w), 13'(h), 13'(s));
            w = clamp_span(13'(w));
            h = clamp_span(13'(h));
            n_rows = $urandom_range(1, (h < 9) ? h + 1 : 9);
            open_frame = ($urandom_range(0, 99) < 85);
            for (int unsigned i = 0; i < n_rows; i++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 6)
                    send_lane_row($urandom_range(1, w), open_frame);
                else if (kind < 10)
                begin
                    // broken row, restarted by a frame start
                    send_lane_row($urandom_range(1, w), open_frame);
                    send_lane_row(w, 1'b1);
                end
                else
                    send_lane_row(w, open_frame);
                open_frame = 1'b0;
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_edge_positions();
        test_frame_restart();
        test_tiny_widths();
        test_short_heights();
        test_counter_overrun();
        test_unused_register();
        test_wide_frames();
        test_random_frames();
        drain_results();
        repeat (8)
            @(negedge clk);
        if (mismatches == 0 && edge_results_due.size() == 0)
            $display("tb_row_lane_edge_scan OK");
        else
            $display("tb_row_lane_edge_scan NOT OK");
        $finish;
    end

endmodule
